// ----- hdl/hwu_pkg.sv -----
`default_nettype none

package hwu_pkg;

   localparam int MAX_OBSTACLES_DEF = 32;
   localparam int WORD_DEPTH_DEF    = 16;

   localparam int COORD_W = 24;
   localparam int SLOT_W  = 5;
   localparam int COUNT_W = 6;
   localparam int OBST_W  = 5;
   localparam int LEN_W   = 5;

   // one half in Q15.8
   localparam logic signed [COORD_W:0] HALF_Q8 = 25'sd128;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_MOVE  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_SPARE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ACT_NONE     = 3'd0,
      ACT_PUSH     = 3'd1,
      ACT_POP      = 3'd2,
      ACT_OVERFLOW = 3'd3,
      ACT_DONE     = 3'd4
   } action_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

   typedef struct packed {
      logic hit;
      logic left;
   } cross_type;

endpackage

`default_nettype wire

// ----- hdl/homotopy_word_update_unit.sv -----
`default_nettype none

// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tuser: operation; tdata: slot, obstacle, old, new
// rsp       out  rsp_tvalid/rsp_tready  tuser: action; tdata: obstacle, leftward, length
// csr       in   csr_wr_en              csr_wr_data: obstacle_count
//
// For load, clear and spare words the result is registered.
// A move scans slots up to the first crossing, at most
// min(obstacle_count, MAX_OBSTACLES), one slot per cycle from the obstacle memory.
// The stack is updated in the cycle that finds the crossing.
// Synchronous reset empties the word and clears obstacle_count; memories keep their data.
// A full output register that is not taken holds off the next request word.
module homotopy_word_update_unit #(
   parameter int MAX_OBSTACLES = hwu_pkg::MAX_OBSTACLES_DEF,
   parameter int WORD_DEPTH    = hwu_pkg::WORD_DEPTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request word
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [1:0] operation
   input  wire logic [1:0]   req_tuser,
   // [4:0] obstacle_slot, [28:5] obstacle_x, [52:29] obstacle_y, [76:53] old_x,
   // [100:77] old_y, [124:101] new_x, [148:125] new_y, [151:149] zero
   input  wire logic [151:0] req_tdata,
   // response word
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [2:0] action
   output logic [2:0]        rsp_tuser,
   // [4:0] crossed_obstacle, [5] crossed_leftward, [10:6] word_length, [15:11] zero
   output logic [15:0]       rsp_tdata,
   // obstacle_count register
   input  wire logic         csr_wr_en,
   input  wire logic [5:0]   csr_wr_data
);

   localparam int IDX_W  = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
   localparam int CNT_W  = $clog2(MAX_OBSTACLES + 1);
   localparam int SA_W   = (WORD_DEPTH > 1) ? $clog2(WORD_DEPTH) : 1;
   localparam int FILL_W = $clog2(WORD_DEPTH + 1);
   localparam int ENT_W  = IDX_W + 1;
   localparam int CW     = hwu_pkg::COORD_W;

   // request fields
   logic [hwu_pkg::SLOT_W-1:0] req_slot;
   logic [CW-1:0] req_obs_x, req_obs_y, req_old_x, req_old_y, req_new_x, req_new_y;
   hwu_pkg::op_type req_op;

   assign req_op    = hwu_pkg::op_type'(req_tuser);
   assign req_slot  = req_tdata[4:0];
   assign req_obs_x = req_tdata[28:5];
   assign req_obs_y = req_tdata[52:29];
   assign req_old_x = req_tdata[76:53];
   assign req_old_y = req_tdata[100:77];
   assign req_new_x = req_tdata[124:101];
   assign req_new_y = req_tdata[148:125];

   // control state
   hwu_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [hwu_pkg::COUNT_W-1:0] count_ff;

   // move coordinates
   logic [CW-1:0] old_x_ff, old_x_in, old_y_ff, old_y_in;
   logic [CW-1:0] new_x_ff, new_x_in, new_y_ff, new_y_in;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   hwu_pkg::action_type       rsp_action_ff, rsp_action_in;
   logic [hwu_pkg::OBST_W-1:0] rsp_obst_ff, rsp_obst_in;
   logic                      rsp_left_ff, rsp_left_in;
   logic [hwu_pkg::LEN_W-1:0] rsp_len_ff, rsp_len_in;

   // memories
   logic             tab_we;
   logic [IDX_W-1:0] tab_wr_addr, tab_rd_addr;
   logic [2*CW-1:0]  tab_rd_data;
   logic             stk_we;
   logic [SA_W-1:0]  stk_wr_addr, stk_rd_addr;
   logic [ENT_W-1:0] stk_wr_data, stk_rd_data;

   hwu_pkg::cross_type cross_res;
   logic               accept;
   logic [CNT_W-1:0]   chk_next;
   logic [CNT_W-1:0]   n_sel;
   logic               last;
   logic [ENT_W-1:0]   entry;

   // obstacle table: {y, x} per slot
   hwu_ram #(
      .WIDTH (2 * CW),
      .DEPTH (MAX_OBSTACLES)
   ) u_tab (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (tab_wr_addr),
      .wr_data ({req_obs_y, req_obs_x}),
      .rd_addr (tab_rd_addr),
      .rd_data (tab_rd_data)
   );

   // homotopy word: {index, leftward} per entry
   hwu_ram #(
      .WIDTH (ENT_W),
      .DEPTH (WORD_DEPTH)
   ) u_stk (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   hwu_cross u_cross (
      .obstacle_x (tab_rd_data[CW-1:0]),
      .obstacle_y (tab_rd_data[2*CW-1:CW]),
      .old_x      (old_x_ff),
      .old_y      (old_y_ff),
      .new_x      (new_x_ff),
      .new_y      (new_y_ff),
      .cross_res  (cross_res)
   );

   assign req_tready = (state_ff == hwu_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign chk_next = CNT_W'(chk_idx_ff + 1'b1);
   assign last     = (chk_next == n_ff);
   assign n_sel    = (32'(count_ff) > MAX_OBSTACLES) ? CNT_W'(MAX_OBSTACLES)
                                                     : CNT_W'(count_ff);
   assign entry    = {chk_idx_ff[IDX_W-1:0], cross_res.left};

   // top of word, kept on the read port; stable through a scan
   assign stk_rd_addr = (fill_ff == '0) ? '0 : SA_W'(fill_ff - 1'b1);
   assign stk_wr_addr = SA_W'(fill_ff);
   assign stk_wr_data = entry;
   assign tab_wr_addr = IDX_W'(req_slot);

   always_comb begin
      state_in      = state_ff;
      chk_idx_in    = chk_idx_ff;
      n_in          = n_ff;
      fill_in       = fill_ff;
      old_x_in      = old_x_ff;
      old_y_in      = old_y_ff;
      new_x_in      = new_x_ff;
      new_y_in      = new_y_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_action_in = rsp_action_ff;
      rsp_obst_in   = rsp_obst_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_len_in    = rsp_len_ff;
      tab_we        = 1'b0;
      tab_rd_addr   = '0;
      stk_we        = 1'b0;

      case (state_ff)
         hwu_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_obst_in = '0;
               rsp_left_in = 1'b0;
               rsp_len_in  = hwu_pkg::LEN_W'(fill_ff);
               case (req_op)
                  hwu_pkg::OP_LOAD: begin
                     // out-of-range slots are dropped
                     tab_we        = (32'(req_slot) < MAX_OBSTACLES);
                     rsp_valid_in  = 1'b1;
                     rsp_action_in = hwu_pkg::ACT_DONE;
                  end
                  hwu_pkg::OP_CLEAR: begin
                     fill_in       = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_action_in = hwu_pkg::ACT_DONE;
                     rsp_len_in    = '0;
                  end
                  hwu_pkg::OP_MOVE: begin
                     old_x_in   = req_old_x;
                     old_y_in   = req_old_y;
                     new_x_in   = req_new_x;
                     new_y_in   = req_new_y;
                     n_in       = n_sel;
                     chk_idx_in = '0;
                     if (n_sel == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_action_in = hwu_pkg::ACT_NONE;
                     end else begin
                        state_in = hwu_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_action_in = hwu_pkg::ACT_NONE;
                  end
               endcase
            end
         end
         hwu_pkg::ST_SCAN: begin
            // table data on the port belongs to slot chk_idx_ff
            tab_rd_addr = last ? '0 : chk_next[IDX_W-1:0];
            if (cross_res.hit) begin
               state_in     = hwu_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_obst_in  = hwu_pkg::OBST_W'(chk_idx_ff);
               rsp_left_in  = cross_res.left;
               if ((fill_ff != '0) &&
                   (stk_rd_data == {chk_idx_ff[IDX_W-1:0], ~cross_res.left})) begin
                  fill_in       = FILL_W'(fill_ff - 1'b1);
                  rsp_action_in = hwu_pkg::ACT_POP;
               end else if (32'(fill_ff) < WORD_DEPTH) begin
                  stk_we        = 1'b1;
                  fill_in       = FILL_W'(fill_ff + 1'b1);
                  rsp_action_in = hwu_pkg::ACT_PUSH;
               end else begin
                  rsp_action_in = hwu_pkg::ACT_OVERFLOW;
               end
               rsp_len_in = hwu_pkg::LEN_W'(fill_in);
            end else if (last) begin
               state_in      = hwu_pkg::ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_action_in = hwu_pkg::ACT_NONE;
               rsp_obst_in   = '0;
               rsp_left_in   = 1'b0;
               rsp_len_in    = hwu_pkg::LEN_W'(fill_ff);
            end else begin
               chk_idx_in = chk_next;
            end
         end
         default: begin
            state_in = hwu_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hwu_pkg::ST_IDLE;
         chk_idx_ff   <= '0;
         n_ff         <= '0;
         fill_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_idx_ff   <= chk_idx_in;
         n_ff         <= n_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      old_x_ff      <= old_x_in;
      old_y_ff      <= old_y_in;
      new_x_ff      <= new_x_in;
      new_y_ff      <= new_y_in;
      rsp_action_ff <= rsp_action_in;
      rsp_obst_ff   <= rsp_obst_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_action_ff;
   assign rsp_tdata  = {5'b0, rsp_len_ff, rsp_left_ff, rsp_obst_ff};

`ifndef SYNTHESIS
   // word never grows past its depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= WORD_DEPTH)
      else $error("homotopy word fill beyond depth");

   // fill moves by one step or drops to empty on a clear
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (fill_ff != $past(fill_ff)) |->
         (fill_ff == FILL_W'($past(fill_ff) + 1'b1)) ||
         (fill_ff == FILL_W'($past(fill_ff) - 1'b1)) || (fill_ff == '0))
      else $error("homotopy word fill jumped");

   // response register is free for the whole scan
   a_scan_rsp_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hwu_pkg::ST_SCAN) |-> !rsp_valid_ff)
      else $error("response pending during scan");

   // a scan that ends leaves a response behind
   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hwu_pkg::ST_SCAN) && (state_in == hwu_pkg::ST_IDLE) |=> rsp_valid_ff)
      else $error("scan ended without response");
`endif

endmodule

`default_nettype wire

// ----- hdl/hwu_ram.sv -----
`default_nettype none

module hwu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/hwu_cross.sv -----
`default_nettype none

// Crossing test of one obstacle against the move segment.
module hwu_cross (
   input  wire logic [hwu_pkg::COORD_W-1:0] obstacle_x,
   input  wire logic [hwu_pkg::COORD_W-1:0] obstacle_y,
   input  wire logic [hwu_pkg::COORD_W-1:0] old_x,
   input  wire logic [hwu_pkg::COORD_W-1:0] old_y,
   input  wire logic [hwu_pkg::COORD_W-1:0] new_x,
   input  wire logic [hwu_pkg::COORD_W-1:0] new_y,
   output hwu_pkg::cross_type               cross_res
);

   logic signed [hwu_pkg::COORD_W:0] bx;
   logic signed [hwu_pkg::COORD_W:0] ox;
   logic signed [hwu_pkg::COORD_W:0] nx;
   logic signed [hwu_pkg::COORD_W-1:0] by;
   logic signed [hwu_pkg::COORD_W-1:0] oy;
   logic signed [hwu_pkg::COORD_W-1:0] ny;
   logic below;
   logic go_left;
   logic go_right;

   always_comb begin
      bx = $signed({obstacle_x[hwu_pkg::COORD_W-1], obstacle_x}) + hwu_pkg::HALF_Q8;
      ox = $signed({old_x[hwu_pkg::COORD_W-1], old_x});
      nx = $signed({new_x[hwu_pkg::COORD_W-1], new_x});
      by = $signed(obstacle_y);
      oy = $signed(old_y);
      ny = $signed(new_y);
      below    = (oy >= by) && (ny >= by);
      go_left  = (ox > bx) && (nx < bx);
      go_right = (ox < bx) && (nx > bx);
      cross_res.hit  = below && (go_left || go_right);
      cross_res.left = go_left;
   end

endmodule

`default_nettype wire
